### rtl/ppq_pkg.sv
package ppq_pkg;

   // Command codes carried in the request word.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Status codes carried in the response word.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Request word.
   typedef struct packed {
      logic        command;
      logic [15:0] proc_id;
      logic [7:0]  prio_level;
      logic [15:0] run_time;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [15:0] out_id;
      logic [7:0]  out_prio;
      logic [15:0] out_time;
      logic        removed_valid;
      logic [1:0]  status;
      logic [4:0]  occupancy;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [15:0] proc_id;
      logic [7:0]  prio_level;
      logic [15:0] run_time;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_REM_RD,
      ST_REM_CMP,
      ST_SHF_RD,
      ST_SHF_WR,
      ST_RESP
   } state_type;

endpackage

### rtl/ppq_ram.sv
module ppq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/priority_process_queue.sv
// Sorted process queue. A word is accepted when start is high and busy is low. Busy then stays
// high until the single response word has been shown for one cycle on rsp_valid, which the
// receiver cannot stall. Entries live in one RAM in ascending priority order, and a small
// sequencer walks the RAM one entry at a time. Each entry is handled by a read state and a
// compare or shift state because the RAM read is registered. The response is shown in the last
// cycle that busy is high. An insert moves every held entry with a larger priority value up one
// slot and then writes the new entry into the hole. A remove first scans the leading group of
// equal-priority entries, plus one entry more when another group follows it, and then closes
// the gap by moving each entry behind the removed one down one slot. Inserting into a full queue
// or removing from an empty one answers in the cycle right after acceptance and leaves the queue
// unchanged. There is no clearing pass after reset.
module priority_process_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ppq_pkg::req_type  req_item,
   output logic              rsp_valid,
   output ppq_pkg::rsp_type  rsp_item
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(ppq_pkg::entry_type);

   ppq_pkg::state_type state_ff, state_in;
   ppq_pkg::req_type   req_ff, req_in;
   ppq_pkg::entry_type best_entry_ff, best_entry_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      best_ff, best_in;
   logic [1:0]         status_ff, status_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [AW-1:0]      ram_raddr;
   ppq_pkg::entry_type ram_wdata;
   ppq_pkg::entry_type ram_rdata;
   logic [EW-1:0]      ram_rdata_raw;

   ppq_pkg::entry_type new_entry;
   logic               scan_first;
   logic               scan_take;
   logic               scan_end;
   logic [AW-1:0]      best_sel;
   logic [CW-1:0]      idx_dec;
   logic [CW-1:0]      idx_inc;
   logic               ins_move;
   logic               full;
   logic               empty;
   logic [31:0]        count_wide;

   ppq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (EW'(ram_wdata)),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = ppq_pkg::entry_type'(ram_rdata_raw);

   // Shared compare and index arithmetic.
   assign new_entry.proc_id    = req_ff.proc_id;
   assign new_entry.prio_level = req_ff.prio_level;
   assign new_entry.run_time   = req_ff.run_time;
   assign idx_dec    = idx_ff - CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign ins_move   = (ram_rdata.prio_level > req_ff.prio_level);
   assign scan_first = (idx_ff == '0);
   assign scan_take  = scan_first ||
                       ((ram_rdata.prio_level == best_entry_ff.prio_level) &&
                        (ram_rdata.run_time < best_entry_ff.run_time));
   assign scan_end   = (!scan_first && (ram_rdata.prio_level != best_entry_ff.prio_level)) ||
                       (idx_inc == count_ff);
   assign best_sel   = scan_take ? idx_ff[AW-1:0] : best_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_item.command == ppq_pkg::CMD_INSERT) begin
                  state_in = full ? ppq_pkg::ST_RESP : ppq_pkg::ST_INS_RD;
               end else begin
                  state_in = empty ? ppq_pkg::ST_RESP : ppq_pkg::ST_REM_RD;
               end
            end
         end
         ppq_pkg::ST_INS_RD: begin
            state_in = (idx_ff == '0) ? ppq_pkg::ST_RESP : ppq_pkg::ST_INS_CMP;
         end
         ppq_pkg::ST_INS_CMP: begin
            state_in = ins_move ? ppq_pkg::ST_INS_RD : ppq_pkg::ST_RESP;
         end
         ppq_pkg::ST_REM_RD: begin
            state_in = ppq_pkg::ST_REM_CMP;
         end
         ppq_pkg::ST_REM_CMP: begin
            state_in = scan_end ? ppq_pkg::ST_SHF_RD : ppq_pkg::ST_REM_RD;
         end
         ppq_pkg::ST_SHF_RD: begin
            state_in = (idx_ff == count_ff) ? ppq_pkg::ST_RESP : ppq_pkg::ST_SHF_WR;
         end
         ppq_pkg::ST_SHF_WR: begin
            state_in = ppq_pkg::ST_SHF_RD;
         end
         ppq_pkg::ST_RESP: begin
            state_in = ppq_pkg::ST_IDLE;
         end
         default: begin
            state_in = ppq_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: RAM controls, handshake and response word.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = new_entry;
      ram_raddr = idx_ff[AW-1:0];
      case (state_ff)
         ppq_pkg::ST_INS_RD: begin
            // An empty hole at slot zero takes the new entry at once.
            ram_we    = (idx_ff == '0);
            ram_raddr = idx_dec[AW-1:0];
         end
         ppq_pkg::ST_INS_CMP: begin
            // Either move the larger entry up into the hole or fill the hole.
            ram_we    = 1'b1;
            ram_wdata = ins_move ? ram_rdata : new_entry;
         end
         ppq_pkg::ST_SHF_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_dec[AW-1:0];
            ram_wdata = ram_rdata;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase

      busy      = (state_ff != ppq_pkg::ST_IDLE);
      rsp_valid = (state_ff == ppq_pkg::ST_RESP);

      rsp_item.removed_valid = (req_ff.command == ppq_pkg::CMD_REMOVE) &&
                               (status_ff == ppq_pkg::STAT_OK);
      rsp_item.out_id    = rsp_item.removed_valid ? best_entry_ff.proc_id : '0;
      rsp_item.out_prio  = rsp_item.removed_valid ? best_entry_ff.prio_level : '0;
      rsp_item.out_time  = rsp_item.removed_valid ? best_entry_ff.run_time : '0;
      rsp_item.status    = status_ff;
      rsp_item.occupancy = count_wide[4:0];
   end

   assign count_wide = 32'(count_ff);

   // Datapath next values.
   always_comb begin
      req_in        = req_ff;
      best_entry_in = best_entry_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      case (state_ff)
         ppq_pkg::ST_IDLE: begin
            if (start) begin
               req_in    = req_item;
               status_in = ppq_pkg::STAT_OK;
               if (req_item.command == ppq_pkg::CMD_INSERT) begin
                  idx_in = count_ff;
                  if (full) begin
                     status_in = ppq_pkg::STAT_FULL;
                  end
               end else begin
                  idx_in = '0;
                  if (empty) begin
                     status_in = ppq_pkg::STAT_EMPTY;
                  end
               end
            end
         end
         ppq_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               count_in = count_ff + CW'(1);
            end
         end
         ppq_pkg::ST_INS_CMP: begin
            if (ins_move) begin
               idx_in = idx_dec;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ppq_pkg::ST_REM_CMP: begin
            // Track the least run time in the leading group; the earliest wins ties.
            if (scan_take) begin
               best_entry_in = ram_rdata;
            end
            best_in = best_sel;
            idx_in  = scan_end ? (CW'(best_sel) + CW'(1)) : idx_inc;
         end
         ppq_pkg::ST_SHF_RD: begin
            if (idx_ff == count_ff) begin
               count_in = count_ff - CW'(1);
            end
         end
         ppq_pkg::ST_SHF_WR: begin
            idx_in = idx_inc;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      best_entry_ff <= best_entry_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      status_ff     <= status_in;
   end

`ifndef NO_ASSERTIONS
   // The fill count never passes the depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // A response word lasts one cycle and the block is free right after it.
   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response not a single-cycle pulse");

   // An accepted word always makes the block busy.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // A removed entry is always reported with an ok status.
   a_removed_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.removed_valid) |-> (rsp_item.status == ppq_pkg::STAT_OK))
      else $error("removed entry with error status");

   // A successful remove lowers the count by one on the way into the response cycle.
   a_remove_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.removed_valid) |-> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove count mismatch");
`endif

endmodule
